// ===== sv/rshc_pkg.sv =====
// types, widths and step factor constants for the rain sensor heater control
`timescale 1ns / 1ps
`default_nettype none

package rshc_pkg;

   localparam int UPDATE_PERIOD_S = 10;
   localparam int PERIOD_MS = ((UPDATE_PERIOD_S < 3) ? 3 : UPDATE_PERIOD_S) * 1000;

   localparam int TEMP_W = 15;
   localparam int LEVEL_W = 23;
   localparam int TIME_W = 32;
   localparam int DUTY_W = 10;
   localparam int MODE_W = 2;
   localparam int FACT_W = 18;
   localparam int ARITH_W = 41;
   localparam int CNT_W = 6;
   localparam int NUM_STEPS = 7;

   localparam logic [LEVEL_W-1:0] LEVEL_FULL = LEVEL_W'(6553600);

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef struct packed {
      logic [TIME_W-1:0]  now_seconds;
      logic [TEMP_W-1:0]  ambient_temp;
      logic [TEMP_W-1:0]  rain_sensor_temp;
      logic               sensor_wet;
      logic [LEVEL_W-1:0] measured_level;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0]  duty;
      logic [MODE_W-1:0]  heater_mode;
      logic [LEVEL_W-1:0] heater_level;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic             op;
      logic [CNT_W-1:0] count;
   } arith_req_type;

   // factor in q16: sqrt(base^2 * 2^32 / period_ms), never zero
   function automatic logic [FACT_W-1:0] step_factor(input longint unsigned base);
      longint unsigned x;
      longint unsigned r;
      longint unsigned bitv;
      x = ((base * base) << 32) / PERIOD_MS;
      r = 0;
      bitv = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + bitv) begin
            x = x - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      if (r == 0) begin
         r = 1;
      end
      return FACT_W'(r);
   endfunction

   localparam logic [FACT_W-1:0] STEP_FACTOR [NUM_STEPS] = '{
      step_factor(140), step_factor(120), step_factor(110), step_factor(106),
      step_factor(104), step_factor(102), step_factor(101)
   };

   localparam logic [17:0] STEP_EDGE [NUM_STEPS] = '{
      18'd800, 18'd400, 18'd300, 18'd200, 18'd100, 18'd50, 18'd30
   };

endpackage

`default_nettype wire

// ===== sv/rshc_serial_arith.sv =====
// bit-serial unsigned multiplier and restoring divider, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module rshc_serial_arith (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire rshc_pkg::arith_req_type         req,
   input  wire logic [rshc_pkg::ARITH_W-1:0]    opa,
   input  wire logic [rshc_pkg::LEVEL_W-1:0]    opb,
   output logic                                 done,
   output logic [rshc_pkg::ARITH_W-1:0]         result
);
   import rshc_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic                 op_ff, op_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [ARITH_W-1:0]   a_ff, a_in;
   logic [ARITH_W-1:0]   b_ff, b_in;
   logic [ARITH_W-1:0]   acc_ff, acc_in;
   logic [LEVEL_W-1:0]   rem_ff, rem_in;
   logic [LEVEL_W:0]     rem_sh;
   logic [LEVEL_W:0]     rem_sub;
   logic [CNT_W-1:0]     idx;

   assign idx = cnt_ff - CNT_W'(1);
   assign rem_sh = {rem_ff, a_ff[idx]};
   assign rem_sub = rem_sh - {1'b0, b_ff[LEVEL_W-1:0]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      if (req.start) begin
         busy_in = 1'b1;
         op_in = req.op;
         cnt_in = req.count;
         a_in = opa;
         b_in = ARITH_W'(opb);
         acc_in = '0;
         rem_in = '0;
      end else if (busy_ff) begin
         if (op_ff == OP_MUL) begin
            if (a_ff[0]) begin
               acc_in = acc_ff + b_ff;
            end
            a_in = a_ff >> 1;
            b_in = b_ff << 1;
         end else begin
            // restoring step: bring down the next numerator bit
            if (rem_sh >= {1'b0, b_ff[LEVEL_W-1:0]}) begin
               rem_in = rem_sub[LEVEL_W-1:0];
               acc_in = {acc_ff[ARITH_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[LEVEL_W-1:0];
               acc_in = {acc_ff[ARITH_W-2:0], 1'b0};
            end
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      op_ff <= op_in;
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign result = acc_ff;

endmodule

`default_nettype wire

// ===== sv/rain_sensor_heater_control.sv =====
// rain sensor heater control: mode machine, target, level step and duty
// one item at a time: an accepted item runs through the mode state, the interpolated target,
// the level step when the error is in a band, and the duty divide before its result is registered;
// the next item is taken after that; the bit-serial multiply/divide unit does one operand bit per cycle
// the next item is taken while the previous result waits on the output register
// synchronous active-high reset: control and configuration registers to their defaults, mode normal, level unloaded
`timescale 1ns / 1ps
`default_nettype none

module rain_sensor_heater_control (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire rshc_pkg::req_type             req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output rshc_pkg::rsp_type                  rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [2:0]                    csr_index,
   input  wire logic [rshc_pkg::TEMP_W-1:0]   csr_wdata
);
   import rshc_pkg::*;

   localparam logic [2:0] REG_AMBIENT_LOW = 3'd0;
   localparam logic [2:0] REG_AMBIENT_HIGH = 3'd1;
   localparam logic [2:0] REG_OFFSET_LOW = 3'd2;
   localparam logic [2:0] REG_OFFSET_HIGH = 3'd3;
   localparam logic [2:0] REG_IMPULSE_OFFSET = 3'd4;
   localparam logic [2:0] REG_IMPULSE_SECONDS = 3'd5;
   localparam logic [2:0] REG_WET_CYCLE = 3'd6;
   localparam logic [2:0] REG_MIN_LEVEL = 3'd7;

   localparam logic [MODE_W-1:0] MODE_NORMAL = 2'd0;
   localparam logic [MODE_W-1:0] MODE_HEAT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PULSE = 2'd2;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_MODE = 4'd1;
   localparam logic [3:0] S_IMUL = 4'd2;
   localparam logic [3:0] S_IDIV = 4'd3;
   localparam logic [3:0] S_ERR = 4'd4;
   localparam logic [3:0] S_LVL = 4'd5;
   localparam logic [3:0] S_CLAMP = 4'd6;
   localparam logic [3:0] S_DUTY = 4'd7;
   localparam logic [3:0] S_OUT = 4'd8;

   localparam logic [CNT_W-1:0] CNT_IMUL = CNT_W'(13);
   localparam logic [CNT_W-1:0] CNT_IDIV = CNT_W'(28);
   localparam logic [CNT_W-1:0] CNT_LMUL = CNT_W'(FACT_W);
   localparam logic [CNT_W-1:0] CNT_LDIV = CNT_W'(LEVEL_W + 16);
   localparam logic [CNT_W-1:0] CNT_DUTY = CNT_W'(17);

   // configuration registers
   logic signed [TEMP_W-1:0] amb_low_ff, amb_low_in;
   logic signed [TEMP_W-1:0] amb_high_ff, amb_high_in;
   logic [12:0]              off_low_ff, off_low_in;
   logic [12:0]              off_high_ff, off_high_in;
   logic [11:0]              imp_off_ff, imp_off_in;
   logic [9:0]               imp_sec_ff, imp_sec_in;
   logic [9:0]               wet_cyc_ff, wet_cyc_in;
   logic [4:0]               min_lvl_ff, min_lvl_in;

   // item registers
   logic [TIME_W-1:0]        now_ff, now_in;
   logic signed [TEMP_W-1:0] amb_ff, amb_in;
   logic signed [TEMP_W-1:0] rain_ff, rain_in;
   logic                     wet_ff, wet_in;
   logic [LEVEL_W-1:0]       meas_ff, meas_in;

   // controller state
   logic [3:0]               state_ff, state_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [TIME_W-1:0]        wet_since_ff, wet_since_in;
   logic                     wet_timing_ff, wet_timing_in;
   logic [TIME_W-1:0]        pulse_since_ff, pulse_since_in;
   logic [LEVEL_W-1:0]       level_ff, level_in;
   logic                     loaded_ff, loaded_in;
   logic signed [16:0]       target_ff, target_in;
   logic [LEVEL_W+1:0]       raw_ff, raw_in;
   logic [DUTY_W-1:0]        duty_ff, duty_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // arithmetic unit
   arith_req_type            arith_req;
   logic [ARITH_W-1:0]       arith_a;
   logic [LEVEL_W-1:0]       arith_b;
   logic                     arith_done;
   logic [ARITH_W-1:0]       arith_res;

   // derived values
   logic signed [16:0]       amb_x, low_x, ol_x, oh_x, imp_x, rain_x;
   logic signed [16:0]       t_hi, t_imp, t_flat, t_int, delta;
   logic signed [15:0]       den, amb_diff;
   logic                     off_neg;
   logic [12:0]              off_mag;
   logic signed [17:0]       err;
   logic [17:0]              e_abs;
   logic                     band_hit;
   logic [FACT_W-1:0]        fsel;
   logic [LEVEL_W+1:0]       minq;
   logic [LEVEL_W-1:0]       lv_clamp;
   logic [LEVEL_W+9:0]       lv_times;

   assign amb_x = 17'(amb_ff);
   assign low_x = 17'(amb_low_ff);
   assign rain_x = 17'(rain_ff);
   assign ol_x = signed'({4'b0, off_low_ff});
   assign oh_x = signed'({4'b0, off_high_ff});
   assign imp_x = signed'({5'b0, imp_off_ff});
   assign t_hi = amb_x + oh_x;
   assign t_imp = amb_x + imp_x;
   assign t_flat = amb_x + ol_x;
   assign delta = off_neg ? -signed'({3'b0, arith_res[13:0]})
                          : signed'({3'b0, arith_res[13:0]});
   assign t_int = t_flat + delta;
   assign den = 16'(amb_high_ff) - 16'(amb_low_ff);
   assign amb_diff = 16'(amb_ff) - 16'(amb_low_ff);
   assign off_neg = off_high_ff < off_low_ff;
   assign off_mag = off_neg ? (off_low_ff - off_high_ff) : (off_high_ff - off_low_ff);
   assign err = 18'(target_ff) - 18'(rain_x);
   assign e_abs = (err < 0) ? 18'(-err) : 18'(err);
   assign minq = {4'b0, min_lvl_ff, 16'b0};
   assign lv_clamp = (raw_ff < minq) ? minq[LEVEL_W-1:0]
                   : (raw_ff > {2'b0, LEVEL_FULL}) ? LEVEL_FULL : raw_ff[LEVEL_W-1:0];
   assign lv_times = {lv_clamp, 10'b0} - {10'b0, lv_clamp};

   // error band: the highest band edge that the error exceeds wins
   always_comb begin
      band_hit = 1'b0;
      fsel = '0;
      for (int i = NUM_STEPS - 1; i >= 0; i--) begin
         if (e_abs > STEP_EDGE[i]) begin
            band_hit = 1'b1;
            fsel = STEP_FACTOR[i];
         end
      end
   end

   // configuration writes
   always_comb begin
      amb_low_in = amb_low_ff;
      amb_high_in = amb_high_ff;
      off_low_in = off_low_ff;
      off_high_in = off_high_ff;
      imp_off_in = imp_off_ff;
      imp_sec_in = imp_sec_ff;
      wet_cyc_in = wet_cyc_ff;
      min_lvl_in = min_lvl_ff;
      if (csr_we) begin
         case (csr_index)
            REG_AMBIENT_LOW:     amb_low_in = csr_wdata;
            REG_AMBIENT_HIGH:    amb_high_in = csr_wdata;
            REG_OFFSET_LOW:      off_low_in = csr_wdata[12:0];
            REG_OFFSET_HIGH:     off_high_in = csr_wdata[12:0];
            REG_IMPULSE_OFFSET:  imp_off_in = csr_wdata[11:0];
            REG_IMPULSE_SECONDS: imp_sec_in = csr_wdata[9:0];
            REG_WET_CYCLE:       wet_cyc_in = csr_wdata[9:0];
            REG_MIN_LEVEL:       min_lvl_in = csr_wdata[4:0];
            default:             amb_low_in = amb_low_ff;
         endcase
      end
   end

   always_comb begin
      logic [MODE_W-1:0] m;
      logic              wt;
      logic [TIME_W-1:0] ws;
      logic [TIME_W-1:0] wet_age;
      logic [TIME_W-1:0] pulse_age;
      state_in = state_ff;
      now_in = now_ff;
      amb_in = amb_ff;
      rain_in = rain_ff;
      wet_in = wet_ff;
      meas_in = meas_ff;
      mode_in = mode_ff;
      wet_since_in = wet_since_ff;
      wet_timing_in = wet_timing_ff;
      pulse_since_in = pulse_since_ff;
      level_in = level_ff;
      loaded_in = loaded_ff;
      target_in = target_ff;
      raw_in = raw_ff;
      duty_in = duty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in = rsp_data_ff;
      arith_req = '0;
      arith_a = '0;
      arith_b = '0;
      m = mode_ff;
      wt = wet_timing_ff;
      ws = wet_since_ff;
      wet_age = now_ff - wet_since_ff;
      pulse_age = now_ff - pulse_since_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               now_in = req_data.now_seconds;
               amb_in = req_data.ambient_temp;
               rain_in = req_data.rain_sensor_temp;
               wet_in = req_data.sensor_wet;
               meas_in = req_data.measured_level;
               state_in = S_MODE;
            end
         end
         S_MODE: begin
            if (!loaded_ff) begin
               level_in = meas_ff;
               loaded_in = 1'b1;
            end
            if (wet_ff && m == MODE_NORMAL) begin
               if (!wt) begin
                  ws = now_ff;
                  wt = 1'b1;
               end else if (wet_age >= {22'b0, wet_cyc_ff}) begin
                  wt = 1'b0;
                  m = MODE_HEAT;
               end
            end else begin
               wt = 1'b0;
            end
            if (m == MODE_PULSE && pulse_age > {22'b0, imp_sec_ff}) begin
               m = MODE_NORMAL;
               wt = 1'b0;
            end
            mode_in = m;
            wet_timing_in = wt;
            wet_since_in = ws;
            state_in = S_ERR;
            if (m == MODE_NORMAL) begin
               if (amb_ff < amb_low_ff) begin
                  target_in = ol_x;
               end else if (amb_ff > amb_high_ff) begin
                  target_in = t_hi;
               end else if (den == 16'sd0) begin
                  target_in = (t_flat < low_x) ? ol_x : t_flat;
               end else begin
                  arith_req.start = 1'b1;
                  arith_req.op = OP_MUL;
                  arith_req.count = CNT_IMUL;
                  arith_a = ARITH_W'(off_mag);
                  arith_b = LEVEL_W'(amb_diff[14:0]);
                  state_in = S_IMUL;
               end
            end else begin
               target_in = t_imp;
            end
         end
         S_IMUL: begin
            if (arith_done) begin
               arith_req.start = 1'b1;
               arith_req.op = OP_DIV;
               arith_req.count = CNT_IDIV;
               arith_a = arith_res;
               arith_b = LEVEL_W'(den[14:0]);
               state_in = S_IDIV;
            end
         end
         S_IDIV: begin
            if (arith_done) begin
               // interpolated target below the low threshold falls back to the bare offset
               target_in = (t_int < low_x) ? ol_x : t_int;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            state_in = S_CLAMP;
            if (mode_ff == MODE_HEAT && rain_x < target_ff) begin
               raw_in = {2'b0, LEVEL_FULL};
            end else begin
               if (mode_ff == MODE_HEAT) begin
                  mode_in = MODE_PULSE;
                  pulse_since_in = now_ff;
               end
               if (!band_hit) begin
                  raw_in = {2'b0, level_ff};
               end else if (rain_x > target_ff) begin
                  arith_req.start = 1'b1;
                  arith_req.op = OP_DIV;
                  arith_req.count = CNT_LDIV;
                  arith_a = ARITH_W'({level_ff, 16'b0});
                  arith_b = LEVEL_W'(fsel);
                  state_in = S_LVL;
               end else begin
                  arith_req.start = 1'b1;
                  arith_req.op = OP_MUL;
                  arith_req.count = CNT_LMUL;
                  arith_a = ARITH_W'(fsel);
                  arith_b = level_ff;
                  state_in = S_LVL;
               end
            end
         end
         S_LVL: begin
            if (arith_done) begin
               if (rain_x > target_ff) begin
                  // a factor below one on long periods can push the quotient past the top
                  raw_in = (|arith_res[ARITH_W-1:LEVEL_W+2]) ? '1 : arith_res[LEVEL_W+1:0];
               end else begin
                  raw_in = arith_res[ARITH_W-1:16];
               end
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            level_in = lv_clamp;
            arith_req.start = 1'b1;
            arith_req.op = OP_DIV;
            arith_req.count = CNT_DUTY;
            arith_a = ARITH_W'(lv_times[LEVEL_W+9:16]);
            arith_b = LEVEL_W'(100);
            state_in = S_DUTY;
         end
         S_DUTY: begin
            if (arith_done) begin
               duty_in = arith_res[DUTY_W-1:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.duty = duty_ff;
               rsp_data_in.heater_mode = mode_ff;
               rsp_data_in.heater_level = level_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amb_low_ff <= 15'sd0;
         amb_high_ff <= 15'sd2000;
         off_low_ff <= 13'd600;
         off_high_ff <= 13'd400;
         imp_off_ff <= 12'd1000;
         imp_sec_ff <= 10'd60;
         wet_cyc_ff <= 10'd600;
         min_lvl_ff <= 5'd10;
         state_ff <= S_IDLE;
         mode_ff <= MODE_NORMAL;
         wet_since_ff <= '0;
         wet_timing_ff <= 1'b0;
         pulse_since_ff <= '0;
         level_ff <= '0;
         loaded_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         amb_low_ff <= amb_low_in;
         amb_high_ff <= amb_high_in;
         off_low_ff <= off_low_in;
         off_high_ff <= off_high_in;
         imp_off_ff <= imp_off_in;
         imp_sec_ff <= imp_sec_in;
         wet_cyc_ff <= wet_cyc_in;
         min_lvl_ff <= min_lvl_in;
         state_ff <= state_in;
         mode_ff <= mode_in;
         wet_since_ff <= wet_since_in;
         wet_timing_ff <= wet_timing_in;
         pulse_since_ff <= pulse_since_in;
         level_ff <= level_in;
         loaded_ff <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff <= now_in;
      amb_ff <= amb_in;
      rain_ff <= rain_in;
      wet_ff <= wet_in;
      meas_ff <= meas_in;
      target_ff <= target_in;
      raw_ff <= raw_in;
      duty_ff <= duty_in;
      rsp_data_ff <= rsp_data_in;
   end

   rshc_serial_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .req    (arith_req),
      .opa    (arith_a),
      .opb    (arith_b),
      .done   (arith_done),
      .result (arith_res)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

// ===== verif/rain_sensor_heater_control_tb.sv =====
// self-checking testbench for the rain sensor heater control, with its own heater model
`timescale 1ns / 1ps

module rain_sensor_heater_control_tb;
   import rshc_pkg::*;

   localparam logic [1:0] MODE_NORMAL  = 2'd0;
   localparam logic [1:0] MODE_PREHEAT = 2'd1;
   localparam logic [1:0] MODE_PULSE   = 2'd2;

   localparam logic [2:0] REG_AMBIENT_LOW     = 3'd0;
   localparam logic [2:0] REG_AMBIENT_HIGH    = 3'd1;
   localparam logic [2:0] REG_OFFSET_LOW      = 3'd2;
   localparam logic [2:0] REG_OFFSET_HIGH     = 3'd3;
   localparam logic [2:0] REG_IMPULSE_OFFSET  = 3'd4;
   localparam logic [2:0] REG_IMPULSE_SECONDS = 3'd5;
   localparam logic [2:0] REG_WET_CYCLE       = 3'd6;
   localparam logic [2:0] REG_MIN_LEVEL       = 3'd7;

   localparam longint unsigned FULL_LEVEL = 64'd6553600;
   localparam longint unsigned Q16_UNITY = 64'd65536;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 200;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic csr_we;
   logic [2:0] csr_index;
   logic [TEMP_W-1:0] csr_wdata;

   rain_sensor_heater_control dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // error bands and their step bases in hundredths
   int band_edge [0:6] = '{800, 400, 300, 200, 100, 50, 30};
   int band_base [0:6] = '{140, 120, 110, 106, 104, 102, 101};
   int err_span [0:8] = '{0, 30, 50, 100, 200, 300, 400, 800, 1500};

   // heater model: configuration and state
   longint cfg_ambient_low, cfg_ambient_high, cfg_offset_low, cfg_offset_high;
   longint cfg_impulse_offset, cfg_min_level;
   logic [31:0] cfg_impulse_s, cfg_wet_cycle;
   logic [1:0] ctl_mode;
   logic [31:0] wet_start, pulse_start;
   bit wet_armed, level_valid;
   longint unsigned heat_level;

   req_type sensor_updates [$];
   rsp_type expected_outputs [$];
   rsp_type want_rsp;
   int queued_total = 0;
   int results_checked = 0;
   int failures = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   bit req_taken = 1'b0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   logic [31:0] gen_now;
   int wet_left = 0;
   int dry_left = 0;

   function automatic rsp_type heater_step(req_type upd);
      logic [31:0] now;
      longint amb, rain, tgt, err, den, period;
      longint unsigned gain, sq_x, sq_r, sq_bit, floor_lvl;
      bit hit;
      rsp_type res;
      now = upd.now_seconds;
      amb = $signed(upd.ambient_temp);
      rain = $signed(upd.rain_sensor_temp);
      if (!level_valid) begin
         heat_level = upd.measured_level;
         level_valid = 1'b1;
      end
      if (upd.sensor_wet && ctl_mode == MODE_NORMAL) begin
         if (!wet_armed) begin
            wet_start = now;
            wet_armed = 1'b1;
         end else if (now - wet_start >= cfg_wet_cycle) begin
            wet_armed = 1'b0;
            ctl_mode = MODE_PREHEAT;
         end
      end else begin
         wet_armed = 1'b0;
      end
      if (ctl_mode == MODE_PULSE && (now - pulse_start) > cfg_impulse_s) begin
         ctl_mode = MODE_NORMAL;
         wet_armed = 1'b0;
      end
      if (ctl_mode == MODE_NORMAL) begin
         if (amb < cfg_ambient_low) begin
            tgt = cfg_offset_low;
         end else if (amb > cfg_ambient_high) begin
            tgt = amb + cfg_offset_high;
         end else begin
            den = cfg_ambient_high - cfg_ambient_low;
            tgt = amb + cfg_offset_low;
            if (den != 0) begin
               tgt = tgt + ((amb - cfg_ambient_low) * (cfg_offset_high - cfg_offset_low)) / den;
            end
            if (tgt < cfg_ambient_low) begin
               tgt = cfg_offset_low;
            end
         end
      end else begin
         tgt = amb + cfg_impulse_offset;
      end
      if (ctl_mode == MODE_PREHEAT) begin
         if (rain < tgt) begin
            heat_level = FULL_LEVEL;
         end else begin
            pulse_start = now;
            ctl_mode = MODE_PULSE;
         end
      end
      if (ctl_mode != MODE_PREHEAT) begin
         err = tgt - rain;
         if (err < 0) begin
            err = -err;
         end
         gain = Q16_UNITY;
         hit = 1'b0;
         period = (UPDATE_PERIOD_S < 3) ? 3 : UPDATE_PERIOD_S;
         for (int i = 0; i < 7; i++) begin
            if (!hit && err > band_edge[i]) begin
               hit = 1'b1;
               // q16 gain: integer square root of base^2 * 2^32 / period_ms
               sq_x = 64'(band_base[i] * band_base[i]);
               sq_x = (sq_x << 32) / (64'(period) * 64'd1000);
               sq_r = 0;
               sq_bit = 64'h4000_0000_0000_0000;
               while (sq_bit > sq_x) begin
                  sq_bit = sq_bit >> 2;
               end
               while (sq_bit != 0) begin
                  if (sq_x >= sq_r + sq_bit) begin
                     sq_x = sq_x - (sq_r + sq_bit);
                     sq_r = (sq_r >> 1) + sq_bit;
                  end else begin
                     sq_r = sq_r >> 1;
                  end
                  sq_bit = sq_bit >> 2;
               end
               gain = (sq_r == 0) ? 64'd1 : sq_r;
            end
         end
         if (rain > tgt) begin
            heat_level = (heat_level << 16) / gain;
         end else begin
            heat_level = (heat_level * gain) >> 16;
         end
      end
      floor_lvl = 64'(cfg_min_level) << 16;
      if (heat_level < floor_lvl) begin
         heat_level = floor_lvl;
      end
      if (heat_level > FULL_LEVEL) begin
         heat_level = FULL_LEVEL;
      end
      res.duty = DUTY_W'((heat_level * 64'd1023) / FULL_LEVEL);
      res.heater_mode = ctl_mode;
      res.heater_level = heat_level[LEVEL_W-1:0];
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // item driver: inputs move on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (sensor_updates.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data <= sensor_updates.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // monitor: accepted items feed the model, results are checked in order
   always @(posedge clock) begin
      if (reset) begin
         cfg_ambient_low = 0;
         cfg_ambient_high = 2000;
         cfg_offset_low = 600;
         cfg_offset_high = 400;
         cfg_impulse_offset = 1000;
         cfg_impulse_s = 60;
         cfg_wet_cycle = 600;
         cfg_min_level = 10;
         ctl_mode = MODE_NORMAL;
         wet_start = '0;
         pulse_start = '0;
         wet_armed = 1'b0;
         level_valid = 1'b0;
         heat_level = 0;
      end else begin
         if (req_valid && req_ready) begin
            expected_outputs.push_back(heater_step(req_data));
            req_taken = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            results_checked++;
            if (expected_outputs.size() == 0) begin
               $error("result with no item outstanding: duty %0d mode %0d level %0d",
                      rsp_data.duty, rsp_data.heater_mode, rsp_data.heater_level);
               failures++;
            end else begin
               want_rsp = expected_outputs.pop_front();
               if (rsp_data.duty !== want_rsp.duty) begin
                  $error("duty: expected %0d, got %0d", want_rsp.duty, rsp_data.duty);
                  failures++;
               end
               if (rsp_data.heater_mode !== want_rsp.heater_mode) begin
                  $error("heater_mode: expected %0d, got %0d",
                         want_rsp.heater_mode, rsp_data.heater_mode);
                  failures++;
               end
               if (rsp_data.heater_level !== want_rsp.heater_level) begin
                  $error("heater_level: expected %0d, got %0d",
                         want_rsp.heater_level, rsp_data.heater_level);
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic write_reg(input logic [2:0] idx, input int val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[TEMP_W-1:0];
      case (idx)
         REG_AMBIENT_LOW: cfg_ambient_low = $signed(val[TEMP_W-1:0]);
         REG_AMBIENT_HIGH: cfg_ambient_high = $signed(val[TEMP_W-1:0]);
         REG_OFFSET_LOW: cfg_offset_low = val[12:0];
         REG_OFFSET_HIGH: cfg_offset_high = val[12:0];
         REG_IMPULSE_OFFSET: cfg_impulse_offset = val[11:0];
         REG_IMPULSE_SECONDS: cfg_impulse_s = val[9:0];
         REG_WET_CYCLE: cfg_wet_cycle = val[9:0];
         REG_MIN_LEVEL: cfg_min_level = val[4:0];
         default: ;
      endcase
   endtask

   task automatic program_heater(input int amb_lo, input int amb_hi, input int ofs_lo,
                                 input int ofs_hi, input int imp_ofs, input int imp_s,
                                 input int wet_s, input int min_lvl);
      write_reg(REG_AMBIENT_LOW, amb_lo);
      write_reg(REG_AMBIENT_HIGH, amb_hi);
      write_reg(REG_OFFSET_LOW, ofs_lo);
      write_reg(REG_OFFSET_HIGH, ofs_hi);
      write_reg(REG_IMPULSE_OFFSET, imp_ofs);
      write_reg(REG_IMPULSE_SECONDS, imp_s);
      write_reg(REG_WET_CYCLE, wet_s);
      write_reg(REG_MIN_LEVEL, min_lvl);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic add_update(input int amb, input int rain, input bit wet,
                             input logic [LEVEL_W-1:0] meas);
      req_type upd;
      if (rain > 16383) rain = 16383;
      if (rain < -16384) rain = -16384;
      upd.now_seconds = gen_now;
      upd.ambient_temp = amb[TEMP_W-1:0];
      upd.rain_sensor_temp = rain[TEMP_W-1:0];
      upd.sensor_wet = wet;
      upd.measured_level = meas;
      sensor_updates.push_back(upd);
      queued_total++;
      gen_now = gen_now + UPDATE_PERIOD_S;
   endtask

   task automatic queue_updates(input int count);
      int amb, rain, err, lo, hi, k, ofs;
      bit wet;
      for (int n = 0; n < count; n++) begin
         // time mostly moves one period, sometimes jumps
         k = $urandom_range(99);
         if (k < 2) gen_now = $urandom;
         else if (k < 8) gen_now = gen_now + $urandom_range(2000);
         lo = int'((cfg_ambient_low < cfg_ambient_high) ? cfg_ambient_low : cfg_ambient_high);
         hi = int'((cfg_ambient_low < cfg_ambient_high) ? cfg_ambient_high : cfg_ambient_low);
         lo = lo - 500;
         hi = hi + 500;
         k = $urandom_range(99);
         if (k < 55) amb = lo + int'($urandom_range(hi - lo));
         else if (k < 92) amb = int'($urandom_range(25000)) - 10000;
         else amb = int'($urandom_range(32767)) - 16384;
         case ($urandom_range(2))
            0: ofs = int'(cfg_offset_low);
            1: ofs = int'(cfg_offset_high);
            default: ofs = int'(cfg_impulse_offset);
         endcase
         k = $urandom_range(7);
         err = err_span[k] + int'($urandom_range(err_span[k+1] - err_span[k]));
         rain = (amb < cfg_ambient_low) ? int'(cfg_offset_low) : amb + ofs;
         rain = $urandom_range(1) ? rain + err : rain - err;
         if ($urandom_range(99) < 5) rain = int'($urandom_range(32767)) - 16384;
         // wet and dry runs; wet runs can last long enough to start an impulse
         if (wet_left == 0 && dry_left == 0) begin
            if ($urandom_range(1)) begin
               wet_left = $urandom_range(1, int'(cfg_wet_cycle) * 3 / (2 * UPDATE_PERIOD_S) + 4);
            end else begin
               dry_left = $urandom_range(1, 20);
            end
         end
         wet = (wet_left != 0);
         if (wet_left != 0) wet_left--;
         else dry_left--;
         if ($urandom_range(99) < 4) wet = !wet;
         add_update(amb, rain, wet, LEVEL_W'($urandom));
      end
   endtask

   task automatic wait_drained();
      while (results_checked != queued_total) @(negedge clock);
   endtask

   task automatic run_phase(input int count, input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      queue_updates(count);
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed items at reset settings; the first one loads an over-range level
      // and the clock wraps a few items later
      gen_now = 32'hFFFF_FFC0;
      add_update(0, 600, 1'b0, {LEVEL_W{1'b1}});
      for (int i = 0; i < 7; i++) begin
         add_update(1000, 1500 - band_edge[i] - 1, 1'b0, LEVEL_W'($urandom));
         add_update(1000, 1500 + band_edge[i] + 1, 1'b0, LEVEL_W'($urandom));
      end
      add_update(1000, 1470, 1'b0, LEVEL_W'($urandom));
      add_update(1000, 1530, 1'b0, LEVEL_W'($urandom));
      add_update(-10000, -10000, 1'b0, '0);
      add_update(15000, 15000, 1'b0, '0);
      add_update(15000, -10000, 1'b0, '0);
      add_update(-10000, 15000, 1'b0, '0);
      add_update(2000, 2400, 1'b1, '0);
      add_update(0, 0, 1'b1, '0);
      wait_drained();

      // short wet cycle, receiver holds off while items keep coming
      program_heater(0, 2000, 600, 400, 1000, 60, 60, 10);
      hold_request = 1'b1;
      run_phase(200, 0, 0);

      // equal thresholds, high offset below low offset
      program_heater(10000, 10000, 5000, 0, 3000, 600, 1000, 20);
      run_phase(150, 77, 0);

      // zero low offset and zero impulse seconds
      program_heater(-5000, 10000, 0, 5000, 100, 0, 60, 10);
      run_phase(150, 0, 77);

      // thresholds swapped
      program_heater(3000, -2000, 2500, 1200, 1500, 30, 120, 15);
      run_phase(150, 11, 11);

      program_heater(-5000, -5000, 0, 0, 100, 600, 60, 20);
      run_phase(150, 0, 0);

      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_outputs.size() != 0) begin
         $error("%0d results never arrived", expected_outputs.size());
         failures++;
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== rain_sensor_heater_control.f =====
sv/rshc_pkg.sv
sv/rshc_serial_arith.sv
sv/rain_sensor_heater_control.sv
verif/rain_sensor_heater_control_tb.sv
